// ----- rtl/core/hsv_color_adjust_emphasis_unit_macros.svh -----
`ifndef HSV_COLOR_ADJUST_EMPHASIS_UNIT_MACROS_SVH
`define HSV_COLOR_ADJUST_EMPHASIS_UNIT_MACROS_SVH

// same-cycle implication
`define HCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hca assertion failed");

// next-cycle implication
`define HCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hca assertion failed");

`endif

// ----- rtl/core/hca_pkg.sv -----
package hca_pkg;

  localparam int DIV_W      = 24;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int BACK_STAGES = 8;
  localparam int LATENCY    = 1 + DIV_STAGES + 1 + BACK_STAGES;

  localparam logic [7:0]  LEVEL_NEUTRAL = 8'd128;
  localparam logic [16:0] SIXTY_Q8      = 17'd15360;
  localparam logic [16:0] FULL_Q8       = 17'd92160;
  localparam logic [18:0] F_MUL         = 19'd279621;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_SATURATION = 2'd1,
    CFG_HUE        = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } hue_base_e;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [14:0] val;
    logic        gray;
    logic        neg;
    hue_base_e   base;
    logic [2:0]  sel;
  } side_t;

  typedef struct packed {
    logic signed [35:0] sat_prod;
    logic [16:0]        hue;
    logic signed [16:0] val;
    logic [2:0]         sel;
  } hsv_word_t;

  typedef logic [14:0] vtab_t [256];
  typedef logic signed [14:0] btab_t [256];
  typedef logic signed [16:0] gtab_t [256];
  typedef logic [2:0][22:0] gain_row_t;

  function automatic vtab_t build_vtab();
    vtab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 15'((i * 16384 + 127) / 255);
    end
    return t;
  endfunction

  function automatic btab_t build_btab();
    btab_t t;
    int n;
    int x;
    for (int i = 0; i < 256; i++) begin
      n = (i - 128) * 16384;
      if (n >= 0) x = (n + 127) / 255;
      else x = -((-n + 127) / 255);
      t[i] = 15'(x);
    end
    return t;
  endfunction

  function automatic gtab_t build_gtab();
    gtab_t t;
    int n;
    int x;
    for (int i = 0; i < 256; i++) begin
      n = 2 * (i - 128) * 16384;
      if (n >= 0) x = (n + 127) / 255;
      else x = -((-n + 127) / 255);
      t[i] = 17'(16384 + x);
    end
    return t;
  endfunction

  localparam vtab_t V_TAB     = build_vtab();
  localparam btab_t BRI_TAB   = build_btab();
  localparam gtab_t SGAIN_TAB = build_gtab();

  function automatic logic signed [35:0] rnd14(input logic signed [35:0] n);
    logic signed [35:0] m;
    if (n >= 0) begin
      return (n + 36'sd8192) >>> 14;
    end
    m = -n;
    return -((m + 36'sd8192) >>> 14);
  endfunction

  function automatic gain_row_t emph_gain255(input logic [2:0] sel);
    gain_row_t g;
    case (sel)
      3'd0:    g = {23'd4177920, 23'd4177920, 23'd4177920};
      3'd1:    g = {23'd3104115, 23'd3822705, 23'd5176500};
      3'd2:    g = {23'd3685005, 23'd4537215, 23'd3317295};
      3'd3:    g = {23'd2728245, 23'd4094280, 23'd4257225};
      3'd4:    g = {23'd5335110, 23'd4286550, 23'd3781140};
      3'd5:    g = {23'd4090200, 23'd3793635, 23'd4274055};
      3'd6:    g = {23'd4182000, 23'd4123605, 23'd3095955};
      default: g = {23'd3133440, 23'd3133440, 23'd3133440};
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/hsv_color_adjust_emphasis_unit.sv -----
// A word passes the input registers, the divider stages, the a_q register and the hsv2rgb stages B to I.
// Throughput: one word per clock; busy_o stays low, the pipeline never stalls.
// The depth is set by the 24-step radix-2 dividers (6 stages) and the multiply chain.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets the three levels to 128.
// done_o marks each result for one cycle; the receiver cannot stall.
module hsv_color_adjust_emphasis_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [2:0] emphasis_sel_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic       done_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);
  import hca_pkg::*;

  logic       in_acc;
  logic [7:0] bri_q, sat_q, hue_q;

  logic       in_vld_q;
  logic [7:0] red_q, grn_q, blu_q;
  logic [2:0] sel_q;

  logic [7:0]       mx, mn, delta, adiff;
  logic signed [8:0] diff;
  side_t            side_d;
  logic [DIV_W-1:0] num_s, num_h, quo_s, quo_h;

  logic  [DIV_STAGES-1:0] side_vld_q;
  side_t side_q [DIV_STAGES];

  logic [14:0]        a_sat;
  logic [13:0]        a_off;
  logic signed [17:0] a_base, a_h0, a_h1;
  logic signed [8:0]  a_hd;
  logic signed [6:0]  a_hof;
  logic signed [35:0] a_sa, a_ga;
  hsv_word_t          a_d, a_q;
  logic               a_vld_q;

  assign busy_o = 1'b0;
  assign in_acc = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bri_q <= LEVEL_NEUTRAL;
      sat_q <= LEVEL_NEUTRAL;
      hue_q <= LEVEL_NEUTRAL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BRIGHTNESS: bri_q <= cfg_data_i;
        CFG_SATURATION: sat_q <= cfg_data_i;
        CFG_HUE:        hue_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      side_vld_q <= '0;
      a_vld_q    <= 1'b0;
    end else begin
      in_vld_q   <= in_acc;
      side_vld_q <= {side_vld_q[DIV_STAGES-2:0], in_vld_q};
      a_vld_q    <= side_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_in_i;
    grn_q <= green_in_i;
    blu_q <= blue_in_i;
    sel_q <= emphasis_sel_i;
  end

  always_comb begin
    mx = (red_q > grn_q) ? red_q : grn_q;
    if (blu_q > mx) mx = blu_q;
    mn = (red_q < grn_q) ? red_q : grn_q;
    if (blu_q < mn) mn = blu_q;
    delta = mx - mn;
    if (red_q == mx) begin
      side_d.base = BASE_RED;
      diff        = $signed({1'b0, grn_q}) - $signed({1'b0, blu_q});
    end else if (grn_q == mx) begin
      side_d.base = BASE_GREEN;
      diff        = $signed({1'b0, blu_q}) - $signed({1'b0, red_q});
    end else begin
      side_d.base = BASE_BLUE;
      diff        = $signed({1'b0, red_q}) - $signed({1'b0, grn_q});
    end
    adiff       = diff[8] ? 8'(-diff) : diff[7:0];
    side_d.neg  = diff[8];
    side_d.gray = (delta == 8'd0);
    side_d.val  = V_TAB[mx];
    side_d.sel  = sel_q;
    num_s = (DIV_W'(delta) << 14) + DIV_W'(mx[7:1]);
    num_h = (DIV_W'(adiff) << 14) - (DIV_W'(adiff) << 10) + DIV_W'(delta[7:1]);
  end

  hca_div u_div_sat (
    .clk_i (clk_i),
    .num_i (num_s),
    .den_i (mx),
    .quo_o (quo_s)
  );

  hca_div u_div_hue (
    .clk_i (clk_i),
    .num_i (num_h),
    .den_i (delta),
    .quo_o (quo_h)
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        side_q[k] <= side_d;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    a_sat = side_q[DIV_STAGES-1].gray ? 15'd0 : quo_s[14:0];
    a_off = quo_h[13:0];
    case (side_q[DIV_STAGES-1].base)
      BASE_GREEN: a_base = 18'sd30720;
      BASE_BLUE:  a_base = 18'sd61440;
      default:    a_base = 18'sd0;
    endcase
    if (side_q[DIV_STAGES-1].neg) a_h0 = a_base - $signed({4'b0, a_off});
    else                          a_h0 = a_base + $signed({4'b0, a_off});
    if (a_h0 < 0) a_h0 = a_h0 + $signed({1'b0, FULL_Q8});
    if (side_q[DIV_STAGES-1].gray) a_h0 = 18'sd0;

    a_hd = $signed({1'b0, hue_q}) - $signed({1'b0, LEVEL_NEUTRAL});
    if (a_hd < 0) a_hof = -7'((-a_hd) >>> 2);
    else          a_hof = 7'(a_hd >>> 2);
    a_h1 = a_h0 - $signed({{3{a_hof[6]}}, a_hof, 8'b0});
    if (a_h1 >= $signed({1'b0, FULL_Q8}))  a_h1 = a_h1 - $signed({1'b0, FULL_Q8});
    else if (a_h1 < 0)                     a_h1 = a_h1 + $signed({1'b0, FULL_Q8});

    a_sa = 36'($signed({1'b0, a_sat}));
    a_ga = 36'(SGAIN_TAB[sat_q]);
    a_d.sat_prod = a_sa * a_ga;
    a_d.hue      = a_h1[16:0];
    a_d.val      = $signed({2'b0, side_q[DIV_STAGES-1].val}) + 17'(BRI_TAB[bri_q]);
    a_d.sel      = side_q[DIV_STAGES-1].sel;
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  hca_hsv2rgb u_hsv2rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (a_vld_q),
    .word_i  (a_q),
    .vld_o   (done_o),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

`include "hsv_color_adjust_emphasis_unit_macros.svh"

  `HCA_ASSERT_IMP(a_done_has_word, clk_i, rst_ni, done_o, $past(in_acc, LATENCY))
  `HCA_ASSERT_IMP(a_word_gives_done, clk_i, rst_ni, $past(in_acc, LATENCY), done_o)
  `HCA_ASSERT_IMP(a_gray_stays_gray, clk_i, rst_ni, done_o && $past(in_acc && red_in_i == green_in_i && green_in_i == blue_in_i && (emphasis_sel_i == 3'd0 || emphasis_sel_i == 3'd7), LATENCY), red_out_o == green_out_o && green_out_o == blue_out_o)

endmodule

// ----- rtl/core/hca_div.sv -----
module hca_div (
  input  logic                      clk_i,
  input  logic [hca_pkg::DIV_W-1:0] num_i,
  input  logic [7:0]                den_i,
  output logic [hca_pkg::DIV_W-1:0] quo_o
);
  import hca_pkg::*;

  logic [DIV_W-1:0] work_q [DIV_STAGES];
  logic [7:0]       rem_q  [DIV_STAGES];
  logic [7:0]       den_q  [DIV_STAGES];
  logic [DIV_W-1:0] work_d [DIV_STAGES];
  logic [7:0]       rem_d  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] w_in;
    logic [7:0]       r_in;
    logic [7:0]       d_in;

    if (k == 0) begin : g_first
      assign w_in = num_i;
      assign r_in = 8'd0;
      assign d_in = den_i;
    end else begin : g_next
      assign w_in = work_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
    end

    always_comb begin
      logic [8:0]       r;
      logic [DIV_W-1:0] w;
      r = {1'b0, r_in};
      w = w_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        r = {r[7:0], w[DIV_W-1]};
        w = {w[DIV_W-2:0], 1'b0};
        if (r >= {1'b0, d_in}) begin
          r    = r - {1'b0, d_in};
          w[0] = 1'b1;
        end
      end
      work_d[k] = w;
      rem_d[k]  = r[7:0];
    end

    always_ff @(posedge clk_i) begin
      work_q[k] <= work_d[k];
      rem_q[k]  <= rem_d[k];
      den_q[k]  <= d_in;
    end
  end

  assign quo_o = work_q[DIV_STAGES-1];

endmodule

// ----- rtl/core/hca_hsv2rgb.sv -----
module hca_hsv2rgb (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  hca_pkg::hsv_word_t word_i,
  output logic               vld_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);
  import hca_pkg::*;

  function automatic logic [7:0] to_byte(input logic signed [43:0] p);
    logic signed [43:0] r;
    if (p <= 0) begin
      return 8'd0;
    end
    r = p >>> 28;
    if (r > 44'sd255) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  logic [BACK_STAGES-1:0] vld_q, vld_d;

  // stage B
  logic signed [16:0] b_s_q, b_s_d, b_v_q;
  sector_e            b_sec_q, b_sec_d;
  logic [17:0]        b_y_q, b_y_d;
  logic [2:0]         b_sel_q;
  logic [16:0]        b_base;
  logic [16:0]        b_rem;
  // stage C
  logic [36:0]        c_fprod_q, c_fprod_d;
  logic signed [35:0] c_pprod_q, c_pprod_d;
  logic signed [16:0] c_s_q, c_v_q;
  sector_e            c_sec_q;
  logic               c_zero_q;
  logic [2:0]         c_sel_q;
  // stage D
  logic signed [35:0] d_sfprod_q, d_sfprod_d;
  logic signed [19:0] d_p_q, d_p_d;
  logic signed [16:0] d_s_q, d_v_q;
  sector_e            d_sec_q;
  logic               d_zero_q;
  logic [2:0]         d_sel_q;
  logic [14:0]        d_f;
  // stage E
  logic signed [16:0] e_sf_q, e_sf_d, e_s_q, e_v_q;
  logic signed [19:0] e_p_q;
  sector_e            e_sec_q;
  logic               e_zero_q;
  logic [2:0]         e_sel_q;
  // stage F
  logic signed [35:0] f_qprod_q, f_qprod_d, f_tprod_q, f_tprod_d;
  logic signed [19:0] f_p_q;
  logic signed [16:0] f_v_q;
  sector_e            f_sec_q;
  logic               f_zero_q;
  logic [2:0]         f_sel_q;
  // stage G
  logic signed [19:0] g_r_q, g_g_q, g_b_q, g_r_d, g_g_d, g_b_d;
  logic [2:0]         g_sel_q;
  logic signed [19:0] g_q, g_t, g_v;
  // stage H
  logic signed [43:0] h_r_q, h_g_q, h_b_q, h_r_d, h_g_d, h_b_d;
  gain_row_t          h_gain;
  // stage I
  logic [7:0]         i_r_q, i_g_q, i_b_q;

  always_comb begin
    vld_d = {vld_q[BACK_STAGES-2:0], vld_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    b_s_d = 17'(rnd14(word_i.sat_prod));
    if (word_i.hue >= 17'd76800) begin
      b_sec_d = SEC_MR;
      b_base  = 17'd76800;
    end else if (word_i.hue >= 17'd61440) begin
      b_sec_d = SEC_BM;
      b_base  = 17'd61440;
    end else if (word_i.hue >= 17'd46080) begin
      b_sec_d = SEC_CB;
      b_base  = 17'd46080;
    end else if (word_i.hue >= 17'd30720) begin
      b_sec_d = SEC_GC;
      b_base  = 17'd30720;
    end else if (word_i.hue >= SIXTY_Q8) begin
      b_sec_d = SEC_YG;
      b_base  = SIXTY_Q8;
    end else begin
      b_sec_d = SEC_RY;
      b_base  = 17'd0;
    end
    b_rem = word_i.hue - b_base;
    b_y_d = {b_rem[13:0], 4'b0111};
  end

  always_ff @(posedge clk_i) begin
    b_s_q   <= b_s_d;
    b_sec_q <= b_sec_d;
    b_y_q   <= b_y_d;
    b_v_q   <= word_i.val;
    b_sel_q <= word_i.sel;
  end

  always_comb begin
    logic signed [35:0] va;
    logic signed [35:0] oa;
    va        = 36'(b_v_q);
    oa        = 36'(18'sd16384 - 18'(b_s_q));
    c_fprod_d = 37'(b_y_q) * 37'(F_MUL);
    c_pprod_d = va * oa;
  end

  always_ff @(posedge clk_i) begin
    c_fprod_q <= c_fprod_d;
    c_pprod_q <= c_pprod_d;
    c_s_q     <= b_s_q;
    c_v_q     <= b_v_q;
    c_sec_q   <= b_sec_q;
    c_zero_q  <= (b_s_q == 17'sd0);
    c_sel_q   <= b_sel_q;
  end

  always_comb begin
    logic signed [35:0] sa;
    logic signed [35:0] fa;
    d_f        = c_fprod_q[36:22];
    sa         = 36'(c_s_q);
    fa         = 36'($signed({1'b0, d_f}));
    d_sfprod_d = sa * fa;
    d_p_d      = 20'(rnd14(c_pprod_q));
  end

  always_ff @(posedge clk_i) begin
    d_sfprod_q <= d_sfprod_d;
    d_p_q      <= d_p_d;
    d_s_q      <= c_s_q;
    d_v_q      <= c_v_q;
    d_sec_q    <= c_sec_q;
    d_zero_q   <= c_zero_q;
    d_sel_q    <= c_sel_q;
  end

  always_comb begin
    e_sf_d = 17'(rnd14(d_sfprod_q));
  end

  always_ff @(posedge clk_i) begin
    e_sf_q   <= e_sf_d;
    e_s_q    <= d_s_q;
    e_v_q    <= d_v_q;
    e_p_q    <= d_p_q;
    e_sec_q  <= d_sec_q;
    e_zero_q <= d_zero_q;
    e_sel_q  <= d_sel_q;
  end

  always_comb begin
    logic signed [35:0] va;
    logic signed [35:0] qa;
    logic signed [35:0] ta;
    va        = 36'(e_v_q);
    qa        = 36'(18'sd16384 - 18'(e_sf_q));
    ta        = 36'(18'sd16384 - 18'(e_s_q) + 18'(e_sf_q));
    f_qprod_d = va * qa;
    f_tprod_d = va * ta;
  end

  always_ff @(posedge clk_i) begin
    f_qprod_q <= f_qprod_d;
    f_tprod_q <= f_tprod_d;
    f_p_q     <= e_p_q;
    f_v_q     <= e_v_q;
    f_sec_q   <= e_sec_q;
    f_zero_q  <= e_zero_q;
    f_sel_q   <= e_sel_q;
  end

  always_comb begin
    g_q = 20'(rnd14(f_qprod_q));
    g_t = 20'(rnd14(f_tprod_q));
    g_v = 20'(f_v_q);
    if (f_zero_q) begin
      g_r_d = g_v;
      g_g_d = g_v;
      g_b_d = g_v;
    end else begin
      case (f_sec_q)
        SEC_RY: begin
          g_r_d = g_v;   g_g_d = g_t;   g_b_d = f_p_q;
        end
        SEC_YG: begin
          g_r_d = g_q;   g_g_d = g_v;   g_b_d = f_p_q;
        end
        SEC_GC: begin
          g_r_d = f_p_q; g_g_d = g_v;   g_b_d = g_t;
        end
        SEC_CB: begin
          g_r_d = f_p_q; g_g_d = g_q;   g_b_d = g_v;
        end
        SEC_BM: begin
          g_r_d = g_t;   g_g_d = f_p_q; g_b_d = g_v;
        end
        default: begin
          g_r_d = g_v;   g_g_d = f_p_q; g_b_d = g_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    g_r_q   <= g_r_d;
    g_g_q   <= g_g_d;
    g_b_q   <= g_b_d;
    g_sel_q <= f_sel_q;
  end

  always_comb begin
    h_gain = emph_gain255(g_sel_q);
    h_r_d  = 44'(g_r_q) * 44'($signed({1'b0, h_gain[0]}));
    h_g_d  = 44'(g_g_q) * 44'($signed({1'b0, h_gain[1]}));
    h_b_d  = 44'(g_b_q) * 44'($signed({1'b0, h_gain[2]}));
  end

  always_ff @(posedge clk_i) begin
    h_r_q <= h_r_d;
    h_g_q <= h_g_d;
    h_b_q <= h_b_d;
  end

  always_ff @(posedge clk_i) begin
    i_r_q <= to_byte(h_r_q);
    i_g_q <= to_byte(h_g_q);
    i_b_q <= to_byte(h_b_q);
  end

  assign vld_o   = vld_q[BACK_STAGES-1];
  assign red_o   = i_r_q;
  assign green_o = i_g_q;
  assign blue_o  = i_b_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hca_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam longint UNIT_Q14 = 16384;
  localparam longint SECTOR_Q8 = 15360;
  localparam longint TURN_Q8 = 92160;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [7:0] red_in_i;
  logic [7:0] green_in_i;
  logic [7:0] blue_in_i;
  logic [2:0] emphasis_sel_i;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       done_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;

  logic [7:0] bright_lvl;
  logic [7:0] sat_lvl;
  logic [7:0] hue_lvl;
  color_t     adjusted_colors[$];
  int         fail_cnt;
  bit         burst_on;

  hsv_color_adjust_emphasis_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic [7:0] scale_channel(longint c, longint g);
    longint prod;
    longint r;
    prod = c * g * 255;
    if (prod <= 0) begin
      return 8'd0;
    end
    r = prod / (longint'(1) << 28);
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  function automatic color_t adjust_color(logic [7:0] ri, logic [7:0] gi, logic [7:0] bi,
                                          logic [2:0] sel);
    longint gains[8][3] = '{
      '{16384, 16384, 16384}, '{20300, 14991, 12173}, '{13009, 17793, 14451},
      '{16695, 16056, 10699}, '{14828, 16810, 20922}, '{16761, 14877, 16040},
      '{12141, 16171, 16400}, '{12288, 12288, 12288}};
    longint r, g, b, mx, mn, dl, v, s, h, base, diff, off, sg, hof;
    longint f, sf, p, q, t, ro, go, bo;
    color_t c;
    r = ri; g = gi; b = bi;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    dl = mx - mn;
    v = round_div(mx * UNIT_Q14, 255);
    s = 0;
    h = 0;
    if (mx != 0 && dl != 0) begin
      s = round_div(dl * UNIT_Q14, mx);
      if (r == mx) begin
        base = 0; diff = g - b;
      end else if (g == mx) begin
        base = 2 * SECTOR_Q8; diff = b - r;
      end else begin
        base = 4 * SECTOR_Q8; diff = r - g;
      end
      off = round_div(((diff < 0) ? -diff : diff) * SECTOR_Q8, dl);
      h = (diff < 0) ? base - off : base + off;
      if (h < 0) h += TURN_Q8;
    end
    sg = UNIT_Q14 + round_div(2 * (longint'(sat_lvl) - 128) * UNIT_Q14, 255);
    hof = (longint'(hue_lvl) - 128) / 4;
    s = round_div(s * sg, UNIT_Q14);
    v += round_div((longint'(bright_lvl) - 128) * UNIT_Q14, 255);
    h -= hof * 256;
    if (h >= TURN_Q8) h -= TURN_Q8;
    else if (h < 0) h += TURN_Q8;
    if (s == 0) begin
      ro = v; go = v; bo = v;
    end else begin
      f = round_div((h % SECTOR_Q8) * UNIT_Q14, SECTOR_Q8);
      sf = round_div(s * f, UNIT_Q14);
      p = round_div(v * (UNIT_Q14 - s), UNIT_Q14);
      q = round_div(v * (UNIT_Q14 - sf), UNIT_Q14);
      t = round_div(v * (UNIT_Q14 - (s - sf)), UNIT_Q14);
      case (h / SECTOR_Q8)
        0: begin ro = v; go = t; bo = p; end
        1: begin ro = q; go = v; bo = p; end
        2: begin ro = p; go = v; bo = t; end
        3: begin ro = p; go = q; bo = v; end
        4: begin ro = t; go = p; bo = v; end
        default: begin ro = v; go = p; bo = q; end
      endcase
    end
    c.red = scale_channel(ro, gains[sel][0]);
    c.green = scale_channel(go, gains[sel][1]);
    c.blue = scale_channel(bo, gains[sel][2]);
    return c;
  endfunction

  always @(posedge clk_i) begin
    color_t e;
    if (done_o) begin
      if (adjusted_colors.size() == 0) begin
        $error("unexpected word");
        fail_cnt++;
      end else begin
        e = adjusted_colors.pop_front();
        if (red_out_o !== e.red) begin
          $error("red_out: expected %0d actual %0d", e.red, red_out_o);
          fail_cnt++;
        end
        if (green_out_o !== e.green) begin
          $error("green_out: expected %0d actual %0d", e.green, green_out_o);
          fail_cnt++;
        end
        if (blue_out_o !== e.blue) begin
          $error("blue_out: expected %0d actual %0d", e.blue, blue_out_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [2:0] sel,
                            bit pace);
    if (pace) begin
      if (!burst_on && $urandom_range(0, 3) == 0) burst_on = 1'b1;
      while (!burst_on) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        if ($urandom_range(0, 2) == 0) burst_on = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) burst_on = 1'b0;
    end
    start_i <= 1'b1;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    emphasis_sel_i <= sel;
    do @(posedge clk_i); while (busy_o);
    adjusted_colors.push_back(adjust_color(r, g, b, sel));
  endtask

  task automatic drain_pipe();
    int n;
    start_i <= 1'b0;
    @(posedge clk_i);
    n = 0;
    while (adjusted_colors.size() != 0 && n < 2000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_level(cfg_idx_e idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BRIGHTNESS: bright_lvl = val;
      CFG_SATURATION: sat_lvl = val;
      default: hue_lvl = val;
    endcase
  endtask

  task automatic set_levels(logic [7:0] bl, logic [7:0] sl, logic [7:0] hl);
    write_level(CFG_BRIGHTNESS, bl);
    write_level(CFG_SATURATION, sl);
    write_level(CFG_HUE, hl);
  endtask

  task automatic test_corner_colors();
    send_color(8'd0, 8'd0, 8'd0, 3'd0, 0);
    send_color(8'd255, 8'd255, 8'd255, 3'd7, 0);
    send_color(8'd128, 8'd128, 8'd128, 3'd1, 0);
    send_color(8'd255, 8'd0, 8'd0, 3'd2, 0);
    send_color(8'd0, 8'd255, 8'd0, 3'd3, 0);
    send_color(8'd0, 8'd0, 8'd255, 3'd4, 0);
    send_color(8'd255, 8'd255, 8'd0, 3'd5, 0);
    send_color(8'd0, 8'd255, 8'd255, 3'd6, 0);
    send_color(8'd255, 8'd0, 8'd255, 3'd0, 0);
    send_color(8'd200, 8'd10, 8'd90, 3'd1, 0);
    send_color(8'd90, 8'd200, 8'd10, 3'd2, 0);
    send_color(8'd10, 8'd90, 8'd200, 3'd3, 0);
    send_color(8'd170, 8'd85, 8'd85, 3'd4, 0);
    send_color(8'd1, 8'd0, 8'd0, 3'd5, 0);
    send_color(8'd85, 8'd170, 8'd170, 3'd6, 0);
    drain_pipe();
  endtask

  task automatic test_level_extremes();
    set_levels(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd0, 8'd0, 3'd0, 0);
    send_color(8'd10, 8'd200, 8'd30, 3'd1, 0);
    send_color(8'd0, 8'd0, 8'd0, 3'd2, 0);
    drain_pipe();
    set_levels(8'd255, 8'd255, 8'd255);
    send_color(8'd255, 8'd0, 8'd0, 3'd4, 0);
    send_color(8'd30, 8'd40, 8'd250, 3'd7, 0);
    send_color(8'd255, 8'd255, 8'd255, 3'd3, 0);
    drain_pipe();
  endtask

  task automatic test_random_colors(int count);
    for (int i = 0; i < count; i++) begin
      send_color(8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom), 1);
    end
    drain_pipe();
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    emphasis_sel_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BRIGHTNESS;
    cfg_data_i = '0;
    bright_lvl = LEVEL_NEUTRAL;
    sat_lvl = LEVEL_NEUTRAL;
    hue_lvl = LEVEL_NEUTRAL;
    fail_cnt = 0;
    burst_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_colors();
    test_level_extremes();
    set_levels(LEVEL_NEUTRAL, LEVEL_NEUTRAL, LEVEL_NEUTRAL);
    test_random_colors(200);
    for (int k = 0; k < 6; k++) begin
      set_levels(8'($urandom), 8'($urandom), 8'($urandom));
      test_random_colors(110);
    end
    if (fail_cnt == 0 && adjusted_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
